[hdl/ppes_pkg.sv]
// Shared types, constants and helpers for the pendulum Euler-step block.
package ppes_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int STG_W = $clog2(CORDIC_STAGES + 1);

  localparam logic signed [31:0] Q16_TWO_PI  = 32'sd411775;
  localparam logic signed [31:0] Q16_PI      = 32'sd205887;
  localparam logic signed [31:0] Q16_HALF_PI = 32'sd102944;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_USE_SIM   = 3'd0,
    REG_STEP_TIME = 3'd1,
    REG_GRAV      = 3'd2,
    REG_INPUT     = 3'd3,
    REG_DAMP      = 3'd4,
    REG_FLIP      = 3'd5,
    REG_OFFSET    = 3'd6
  } reg_idx_t;

  // datapath operations, one per sequencer step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_VISION,
    OP_RED_START,
    OP_RED_STEP,
    OP_RED_FOLD,
    OP_CORDIC,
    OP_CORDIC_END,
    OP_MUL_TG,
    OP_MUL_IU,
    OP_MUL_TU,
    OP_MUL_TD,
    OP_MUL_DA,
    OP_ACC,
    OP_MUL_DR,
    OP_COMMIT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VISION,
    ST_RED_START,
    ST_RED,
    ST_FOLD,
    ST_CORDIC,
    ST_CORDIC_END,
    ST_TG,
    ST_IU,
    ST_TU,
    ST_TD,
    ST_DA,
    ST_ACC,
    ST_DR,
    ST_COMMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic cordic_done;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [30:0] atan_q30(input logic [4:0] i);
    logic signed [30:0] r;
    unique case (i)
      5'd0:  r = 31'sd843314857;
      5'd1:  r = 31'sd497837830;
      5'd2:  r = 31'sd263043837;
      5'd3:  r = 31'sd133525159;
      5'd4:  r = 31'sd67021687;
      5'd5:  r = 31'sd33543516;
      5'd6:  r = 31'sd16775851;
      5'd7:  r = 31'sd8388437;
      5'd8:  r = 31'sd4194283;
      5'd9:  r = 31'sd2097149;
      default: r = 31'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

[hdl/ppes_ctrl.sv]
// Sequencer for one pendulum step: issues datapath operations and runs the handshake.
module ppes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              use_sim,
  input  ppes_pkg::dp_sts_t sts,
  output ppes_pkg::dp_cmd_t cmd
);
  import ppes_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = OP_NONE;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = use_sim ? ST_RED_START : ST_VISION;
      end
      ST_VISION: begin cmd.op = OP_VISION; state_nxt = ST_OUT; end
      ST_RED_START: begin cmd.op = OP_RED_START; state_nxt = ST_RED; end
      ST_RED: begin
        cmd.op = OP_RED_STEP;
        if (sts.red_done) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin cmd.op = OP_RED_FOLD; state_nxt = ST_CORDIC; end
      ST_CORDIC: begin
        cmd.op = OP_CORDIC;
        if (sts.cordic_done) state_nxt = ST_CORDIC_END;
      end
      ST_CORDIC_END: begin cmd.op = OP_CORDIC_END; state_nxt = ST_TG; end
      ST_TG: begin cmd.op = OP_MUL_TG; state_nxt = ST_IU; end
      ST_IU: begin cmd.op = OP_MUL_IU; state_nxt = ST_TU; end
      ST_TU: begin cmd.op = OP_MUL_TU; state_nxt = ST_TD; end
      ST_TD: begin cmd.op = OP_MUL_TD; state_nxt = ST_DA; end
      ST_DA: begin cmd.op = OP_MUL_DA; state_nxt = ST_ACC; end
      ST_ACC: begin cmd.op = OP_ACC; state_nxt = ST_DR; end
      ST_DR: begin cmd.op = OP_MUL_DR; state_nxt = ST_COMMIT; end
      ST_COMMIT: begin cmd.op = OP_COMMIT; state_nxt = ST_OUT; end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == ST_OUT) else $error("out_tvalid outside output state");
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && out_tvalid) == 1'b0) else $error("accept while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");

endmodule

[hdl/ppes_dp.sv]
// Datapath: range reduction, CORDIC, shared multiplier and state registers.
module ppes_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ppes_pkg::dp_cmd_t        cmd,
  output ppes_pkg::dp_sts_t        sts,
  input  logic                     in_accept,
  input  logic signed [31:0]       drive_accel,
  input  logic signed [31:0]       vision_angle,
  input  logic [15:0]              step_time,
  input  logic signed [31:0]       gravity_coeff,
  input  logic signed [31:0]       input_coeff,
  input  logic signed [31:0]       damping_coeff,
  input  logic                     flip_sign,
  input  logic signed [31:0]       angle_offset,
  output logic signed [31:0]       pole_angle,
  output logic signed [31:0]       pole_rate
);
  import ppes_pkg::*;

  logic signed [31:0] u_r, vis_r;
  logic signed [31:0] ang_r, rate_r;
  logic signed [31:0] out_ang_r, out_ang_nxt;
  logic signed [32:0] red_r, red_nxt;       // remainder during reduction
  logic [4:0]         red_cnt_r, red_cnt_nxt;
  logic               neg_cos_r, neg_cos_nxt;
  logic signed [33:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [34:0] z_r, z_nxt;
  logic [STG_W-1:0]   stg_r, stg_nxt;
  logic signed [31:0] sin_r, cos_r, sin_nxt, cos_nxt;
  logic signed [31:0] tg_r, t_r, td_r, acc_r, na_r;
  logic signed [31:0] tg_nxt, t_nxt, td_nxt, acc_nxt, na_nxt;
  logic signed [31:0] ang_nxt, rate_nxt;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] mq;
  logic signed [33:0] dx, dy, xs, ys;
  logic signed [32:0] twopi_sh, fold;
  logic signed [33:0] vd;
  logic signed [32:0] dv;

  // shared multiplier operand select
  always_comb begin
    ma = gravity_coeff;
    mb = sin_r;
    unique case (cmd.op)
      OP_MUL_IU: begin ma = input_coeff; mb = u_r; end
      OP_MUL_TU: begin ma = t_r; mb = cos_r; end
      OP_MUL_TD: begin ma = damping_coeff; mb = rate_r; end
      OP_MUL_DA: begin ma = {16'd0, step_time}; mb = rate_r; end
      OP_MUL_DR: begin ma = {16'd0, step_time}; mb = acc_r; end
      default: begin ma = gravity_coeff; mb = sin_r; end
    endcase
    prod = ma * mb;
    mq = sat32(66'(prod >>> 16));
  end

  always_comb begin
    red_nxt = red_r; red_cnt_nxt = red_cnt_r; neg_cos_nxt = neg_cos_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; stg_nxt = stg_r;
    sin_nxt = sin_r; cos_nxt = cos_r;
    tg_nxt = tg_r; t_nxt = t_r; td_nxt = td_r; acc_nxt = acc_r; na_nxt = na_r;
    ang_nxt = ang_r; rate_nxt = rate_r; out_ang_nxt = out_ang_r;
    twopi_sh = 33'(Q16_TWO_PI) <<< red_cnt_r;
    fold = red_r;
    dx = y_r >>> stg_r;
    dy = x_r >>> stg_r;
    xs = x_r >>> 14;
    ys = y_r >>> 14;
    vd = 34'(vis_r) - 34'(angle_offset);
    dv = 33'sd0;
    unique case (cmd.op)
      OP_VISION: begin
        vd = flip_sign ? -vd : vd;
        out_ang_nxt = sat32(66'(vd));
      end
      // restoring reduction of |angle| by 2*pi, one shifted multiple a cycle;
      // |angle| <= 2^31 gives a quotient below 2^13
      OP_RED_START: begin
        red_nxt = ang_r[31] ? -33'(ang_r) : 33'(ang_r);
        red_cnt_nxt = 5'd12;
      end
      OP_RED_STEP: begin
        if (red_r >= twopi_sh) red_nxt = red_r - twopi_sh;
        red_cnt_nxt = red_cnt_r - 5'd1;
      end
      OP_RED_FOLD: begin
        // truncating remainder takes the sign of the angle; then wrap
        fold = ang_r[31] ? -red_r : red_r;
        if (fold < 0) fold = fold + 33'(Q16_TWO_PI);
        if (fold > 33'(Q16_PI)) fold = fold - 33'(Q16_TWO_PI);
        neg_cos_nxt = 1'b0;
        if (fold > 33'(Q16_HALF_PI)) begin
          fold = 33'(Q16_PI) - fold; neg_cos_nxt = 1'b1;
        end else if (fold < -33'(Q16_HALF_PI)) begin
          fold = -33'(Q16_PI) - fold; neg_cos_nxt = 1'b1;
        end
        z_nxt = 35'(fold) <<< 14;
        x_nxt = CORDIC_GAIN;
        y_nxt = 34'sd0;
        stg_nxt = '0;
      end
      OP_CORDIC: begin
        if (!z_r[34]) begin
          x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - 35'(atan_q30(5'(stg_r)));
        end else begin
          x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + 35'(atan_q30(5'(stg_r)));
        end
        stg_nxt = stg_r + 1'b1;
      end
      OP_CORDIC_END: begin
        if (xs > 34'sd65536) xs = 34'sd65536;
        if (xs < -34'sd65536) xs = -34'sd65536;
        if (ys > 34'sd65536) ys = 34'sd65536;
        if (ys < -34'sd65536) ys = -34'sd65536;
        sin_nxt = 32'(ys);
        cos_nxt = neg_cos_r ? -32'(xs) : 32'(xs);
      end
      OP_MUL_TG: tg_nxt = mq;
      OP_MUL_IU: t_nxt = mq;
      OP_MUL_TU: t_nxt = mq;
      OP_MUL_TD: td_nxt = mq;
      OP_MUL_DA: na_nxt = sat32(66'(ang_r) + 66'(mq));
      OP_ACC:    acc_nxt = sat32(66'(tg_r) - 66'(t_r) - 66'(td_r));
      OP_MUL_DR: rate_nxt = sat32(66'(rate_r) + 66'(mq));
      OP_COMMIT: begin ang_nxt = na_r; out_ang_nxt = na_r; end
      default: dv = 33'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r  <= '0;
      rate_r <= '0;
      stg_r  <= '0;
      red_cnt_r <= '0;
    end else begin
      ang_r  <= ang_nxt;
      rate_r <= rate_nxt;
      stg_r  <= stg_nxt;
      red_cnt_r <= red_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      u_r <= drive_accel;
      vis_r <= vision_angle;
    end
    red_r <= red_nxt; neg_cos_r <= neg_cos_nxt;
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    sin_r <= sin_nxt; cos_r <= cos_nxt;
    tg_r <= tg_nxt; t_r <= t_nxt; td_r <= td_nxt; acc_r <= acc_nxt; na_r <= na_nxt;
    out_ang_r <= out_ang_nxt;
  end

  assign sts.red_done    = (red_cnt_r == 5'd0) && (dv == 33'sd0);
  assign sts.cordic_done = (stg_r == STG_W'(CORDIC_STAGES - 1));
  assign pole_angle = out_ang_r;
  assign pole_rate  = rate_r;

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_CORDIC) |-> stg_r < STG_W'(CORDIC_STAGES))
    else $error("CORDIC stage overrun");
  a_red_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_RED_FOLD) |-> red_r < 33'(Q16_TWO_PI))
    else $error("reduction incomplete");
  a_sin_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.op == OP_CORDIC_END) |-> (sin_r <= 32'sd65536 && sin_r >= -32'sd65536))
    else $error("sine out of range");

endmodule

[hdl/pendulum_plant_euler_step.sv]
// Top level: pendulum plant Euler step with config registers, sequencer and datapath.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata: drive_accel[31:0], vision_angle[63:32]
//  out_    | out | out_tvalid/tready  | out_tdata: pole_angle[31:0], pole_rate[63:32]
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// Simulation item: 13-step range reduction, CORDIC_STAGES CORDIC iterations and six passes
// through one shared 32x32 multiplier. One item at a time; the next is taken in the cycle
// after the result has been taken. Reset clears the pole state and loads register defaults.
// A stalled result holds in out_tdata until out_tready.
module pendulum_plant_euler_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // drive_accel, vision_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // pole_angle, pole_rate
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import ppes_pkg::*;

  logic               use_sim_r, flip_r;
  logic [15:0]        dt_r;
  logic signed [31:0] grav_r, inp_r, damp_r, off_r;
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic signed [31:0] pole_angle, pole_rate;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_sim_r <= 1'b1; dt_r <= 16'd66; grav_r <= '0; inp_r <= '0;
      damp_r <= '0; flip_r <= 1'b0; off_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_USE_SIM:   use_sim_r <= cfg_wdata[0];
        REG_STEP_TIME: dt_r <= cfg_wdata[15:0];
        REG_GRAV:      grav_r <= cfg_wdata;
        REG_INPUT:     inp_r <= cfg_wdata;
        REG_DAMP:      damp_r <= cfg_wdata;
        REG_FLIP:      flip_r <= cfg_wdata[0];
        REG_OFFSET:    off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ppes_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .use_sim(use_sim_r), .sts, .cmd
  );

  ppes_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_accept(in_tvalid && in_tready),
    .drive_accel(in_tdata[31:0]), .vision_angle(in_tdata[63:32]),
    .step_time(dt_r), .gravity_coeff(grav_r), .input_coeff(inp_r),
    .damping_coeff(damp_r), .flip_sign(flip_r), .angle_offset(off_r),
    .pole_angle, .pole_rate
  );

  assign out_tdata = {pole_rate, pole_angle};

endmodule
